// ===== design/tsbc_pkg.sv =====
// ----------------------------------------------------------------------------
// tsbc_pkg
// Shared types and the initial table images of the byte stream cipher.
// ----------------------------------------------------------------------------
package tsbc_pkg;

    localparam int TABLE_DEPTH = 256;

    typedef logic [7:0] byte_t;

    // one word of the combined substitution/mixing memory
    typedef struct packed {
        byte_t subst;
        byte_t mix;
    } sm_word_t;

    localparam logic FUNC_ENCRYPT = 1'b0;
    localparam logic FUNC_DECRYPT = 1'b1;

    localparam byte_t MIX_INIT [TABLE_DEPTH] = '{
        8'h30, 8'h0b, 8'h90, 8'h8d, 8'heb, 8'hde, 8'h14, 8'hbc,
        8'h2b, 8'he2, 8'haa, 8'h34, 8'h61, 8'hb2, 8'had, 8'h6b,
        8'h3a, 8'he9, 8'ha6, 8'hf4, 8'h66, 8'h4f, 8'hc1, 8'h38,
        8'hdc, 8'h24, 8'hc5, 8'h60, 8'h8e, 8'hdb, 8'h50, 8'hac,
        8'h49, 8'hb8, 8'h29, 8'he0, 8'hb7, 8'hed, 8'h29, 8'h80,
        8'h75, 8'h43, 8'h67, 8'h1b, 8'h6e, 8'h20, 8'h5f, 8'h1f,
        8'h5c, 8'h26, 8'h9c, 8'h1a, 8'hd9, 8'h1e, 8'hdc, 8'h7b,
        8'h32, 8'h20, 8'hfc, 8'hd1, 8'h3a, 8'hc4, 8'h02, 8'h25,
        8'hd3, 8'h0f, 8'h83, 8'h75, 8'hdd, 8'h3f, 8'h3a, 8'h56,
        8'h63, 8'hd9, 8'h5c, 8'hc0, 8'h2b, 8'h9f, 8'h8a, 8'h4f,
        8'h56, 8'he9, 8'h29, 8'h8b, 8'h06, 8'hd5, 8'h1e, 8'h2d,
        8'h17, 8'hc5, 8'haa, 8'h0e, 8'h4e, 8'hf6, 8'h1a, 8'h8b,
        8'h0e, 8'h3b, 8'h19, 8'h33, 8'h99, 8'h54, 8'h2e, 8'hd1,
        8'h6e, 8'h01, 8'hc5, 8'h7a, 8'hf1, 8'h06, 8'h69, 8'h35,
        8'h27, 8'h6f, 8'h79, 8'h97, 8'h8f, 8'hf9, 8'h35, 8'h1c,
        8'hd4, 8'h2c, 8'hd5, 8'h13, 8'h86, 8'h9a, 8'h7d, 8'h85,
        8'hbe, 8'h77, 8'h75, 8'h7a, 8'h61, 8'h25, 8'haf, 8'h5a,
        8'h5c, 8'h19, 8'h1d, 8'h24, 8'hda, 8'hf8, 8'h19, 8'h41,
        8'hba, 8'hc2, 8'h84, 8'h66, 8'he7, 8'hd1, 8'h09, 8'h07,
        8'h2f, 8'h6c, 8'h80, 8'h55, 8'h29, 8'h45, 8'h24, 8'h58,
        8'h72, 8'h6b, 8'hd5, 8'h8f, 8'ha5, 8'h16, 8'he8, 8'h19,
        8'h7c, 8'h10, 8'he7, 8'hfa, 8'hf2, 8'hdc, 8'hf0, 8'h36,
        8'h6d, 8'hef, 8'hd2, 8'h90, 8'h4c, 8'h16, 8'h52, 8'h94,
        8'hc2, 8'h96, 8'h6e, 8'h5e, 8'h26, 8'h96, 8'h95, 8'he5,
        8'h43, 8'h03, 8'h52, 8'hc9, 8'h1a, 8'h18, 8'h52, 8'h21,
        8'h09, 8'h08, 8'h6e, 8'h38, 8'hcc, 8'h89, 8'hc8, 8'h6a,
        8'hec, 8'hff, 8'h18, 8'h43, 8'h73, 8'hed, 8'h67, 8'hf3,
        8'h79, 8'h08, 8'hcd, 8'hb5, 8'h2c, 8'h68, 8'h5b, 8'h1a,
        8'h1a, 8'h19, 8'he5, 8'h2c, 8'h91, 8'h39, 8'h02, 8'h5d,
        8'he2, 8'h89, 8'h69, 8'h8c, 8'h9e, 8'hba, 8'h33, 8'ha2,
        8'h56, 8'hde, 8'hc1, 8'h58, 8'h71, 8'h92, 8'h9c, 8'hbf,
        8'hfa, 8'h32, 8'hd4, 8'hd0, 8'h48, 8'h44, 8'h79, 8'h4d
    };

    localparam byte_t SUBST_INIT [TABLE_DEPTH] = '{
        8'd11,  8'd104, 8'd171, 8'd74,  8'd222, 8'd235, 8'd108, 8'd150,
        8'd216, 8'd185, 8'd52,  8'd170, 8'd178, 8'd97,  8'd13,  8'd64,
        8'd168, 8'd58,  8'd244, 8'd106, 8'd79,  8'd102, 8'd180, 8'd89,
        8'd65,  8'd34,  8'd225, 8'd42,  8'd118, 8'd94,  8'd87,  8'd46,
        8'd22,  8'd198, 8'd224, 8'd41,  8'd76,  8'd132, 8'd189, 8'd113,
        8'd67,  8'd157, 8'd197, 8'd77,  8'd8,   8'd81,  8'd9,   8'd101,
        8'd128, 8'd92,  8'd140, 8'd176, 8'd172, 8'd119, 8'd174, 8'd25,
        8'd202, 8'd228, 8'd71,  8'd26,  8'd196, 8'd209, 8'd183, 8'd68,
        8'd173, 8'd29,  8'd39,  8'd179, 8'd59,  8'd51,  8'd86,  8'd61,
        8'd253, 8'd99,  8'd192, 8'd49,  8'd181, 8'd254, 8'd93,  8'd138,
        8'd16,  8'd70,  8'd199, 8'd117, 8'd100, 8'd124, 8'd109, 8'd10,
        8'd15,  8'd193, 8'd125, 8'd223, 8'd137, 8'd230, 8'd145, 8'd50,
        8'd252, 8'd126, 8'd156, 8'd220, 8'd213, 8'd153, 8'd146, 8'd215,
        8'd30,  8'd5,   8'd206, 8'd160, 8'd152, 8'd177, 8'd203, 8'd112,
        8'd45,  8'd245, 8'd161, 8'd163, 8'd249, 8'd40,  8'd219, 8'd38,
        8'd184, 8'd208, 8'd130, 8'd84,  8'd169, 8'd127, 8'd133, 8'd134,
        8'd155, 8'd190, 8'd166, 8'd143, 8'd147, 8'd90,  8'd107, 8'd175,
        8'd33,  8'd167, 8'd237, 8'd142, 8'd234, 8'd218, 8'd211, 8'd162,
        8'd12,  8'd227, 8'd18,  8'd62,  8'd182, 8'd191, 8'd6,   8'd43,
        8'd85,  8'd95,  8'd188, 8'd105, 8'd247, 8'd83,  8'd115, 8'd78,
        8'd88,  8'd151, 8'd238, 8'd54,  8'd56,  8'd165, 8'd66,  8'd232,
        8'd233, 8'd154, 8'd250, 8'd149, 8'd55,  8'd242, 8'd123, 8'd240,
        8'd239, 8'd241, 8'd194, 8'd210, 8'd164, 8'd2,   8'd21,  8'd139,
        8'd20,  8'd3,   8'd148, 8'd217, 8'd32,  8'd1,   8'd229, 8'd75,
        8'd144, 8'd214, 8'd201, 8'd37,  8'd36,  8'd47,  8'd73,  8'd195,
        8'd207, 8'd114, 8'd44,  8'd187, 8'd205, 8'd28,  8'd122, 8'd226,
        8'd116, 8'd236, 8'd23,  8'd60,  8'd251, 8'd121, 8'd243, 8'd80,
        8'd200, 8'd212, 8'd159, 8'd246, 8'd48,  8'd120, 8'd135, 8'd0,
        8'd19,  8'd4,   8'd31,  8'd129, 8'd96,  8'd186, 8'd7,   8'd63,
        8'd204, 8'd69,  8'd248, 8'd111, 8'd82,  8'd27,  8'd136, 8'd98,
        8'd14,  8'd110, 8'd158, 8'd131, 8'd17,  8'd35,  8'd231, 8'd221,
        8'd57,  8'd91,  8'd255, 8'd24,  8'd141, 8'd53,  8'd103, 8'd72
    };

endpackage

// ===== design/tsbc_ram.sv =====
// ----------------------------------------------------------------------------
// tsbc_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module tsbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr_a,
    output logic [WIDTH-1:0] rdata_a,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read-first: a read at the address being written returns the old word
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// ===== design/table_shuffle_byte_stream_cipher_top.sv =====
// A request steps PH_PART, PH_W1, PH_W2, PH_W3; a decrypt passes PH_RD before PH_PART.
// Throughput is set by the three write-backs through the single write port of the
// substitution/mixing memory, and PH_W3 holds while the output is not taken.
// A second request is held in an input register while one is in work.
// Reset: a pass over all 256 entries loads the initial tables into both memories; no
// request is taken during that pass. The chain state resets to zero.
// ----------------------------------------------------------------------------
// table_shuffle_byte_stream_cipher_top
// Self-modifying table cipher, one byte per request, encrypt or decrypt.
// ----------------------------------------------------------------------------
module table_shuffle_byte_stream_cipher_top
    import tsbc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       func,
    input  logic [7:0] data_in,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] data_out
);

    localparam logic [2:0] PH_INIT = 3'd0;
    localparam logic [2:0] PH_IDLE = 3'd1;
    localparam logic [2:0] PH_RD   = 3'd2;
    localparam logic [2:0] PH_PART = 3'd3;
    localparam logic [2:0] PH_W1   = 3'd4;
    localparam logic [2:0] PH_W2   = 3'd5;
    localparam logic [2:0] PH_W3   = 3'd6;

    logic [2:0] phase_reg, phase_next;
    byte_t      init_cnt_reg;
    byte_t      chain_reg;
    logic       hold_valid_reg;
    logic       hold_func_reg;
    byte_t      hold_data_reg;
    logic       out_valid_reg;
    byte_t      out_data_reg;

    logic       func_reg;
    byte_t      idx_reg;
    byte_t      partner_reg;
    byte_t      result_reg;
    byte_t      new_chain_reg;
    sm_word_t   wi_reg;
    sm_word_t   ws_reg;
    sm_word_t   wp_word_reg;
    sm_word_t   ws_word_reg;
    logic       wp_en_reg;
    logic       ws_en_reg;

    logic       start;
    logic       finish;
    logic       in_take;
    byte_t      enc_idx;

    // memory ports
    logic       sm_we;
    byte_t      sm_waddr;
    sm_word_t   sm_wdata;
    byte_t      sm_raddr_a;
    byte_t      sm_raddr_b;
    sm_word_t   sm_rdata_a;
    sm_word_t   sm_rdata_b;
    logic       inv_we;
    byte_t      inv_waddr;
    byte_t      inv_wdata;
    byte_t      inv_raddr;
    byte_t      inv_rdata;

    // update terms, valid in PH_W1 (sm_rdata_a holds the partner word)
    byte_t      partner;
    logic       p_eq_i;
    logic       s_eq_i;
    logic       s_eq_p;
    byte_t      new_s_idx;
    byte_t      m_s_new;
    byte_t      new_m_idx;
    sm_word_t   w_idx_word;

    tsbc_ram #(
        .WIDTH ($bits(sm_word_t)),
        .DEPTH (TABLE_DEPTH)
    ) u_sm_ram (
        .clk     (clk),
        .we      (sm_we),
        .waddr   (sm_waddr),
        .wdata   (sm_wdata),
        .raddr_a (sm_raddr_a),
        .rdata_a (sm_rdata_a),
        .raddr_b (sm_raddr_b),
        .rdata_b (sm_rdata_b)
    );

    tsbc_ram #(
        .WIDTH ($bits(byte_t)),
        .DEPTH (TABLE_DEPTH)
    ) u_inv_ram (
        .clk     (clk),
        .we      (inv_we),
        .waddr   (inv_waddr),
        .wdata   (inv_wdata),
        .raddr_a (inv_raddr),
        .rdata_a (inv_rdata),
        .raddr_b (inv_raddr),
        .rdata_b ()
    );

    assign in_ready  = !hold_valid_reg && (phase_reg != PH_INIT);
    assign in_take   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign data_out  = out_data_reg;
    assign enc_idx   = chain_reg + hold_data_reg;

    always_comb
    begin
        partner    = wi_reg.mix;
        p_eq_i     = (partner == idx_reg);
        s_eq_i     = (chain_reg == idx_reg);
        s_eq_p     = (chain_reg == partner);
        new_s_idx  = p_eq_i ? wi_reg.subst : sm_rdata_a.subst;
        // when the chain state equals the index the mixing entry is cleared first
        m_s_new    = s_eq_i ? 8'h00 : (ws_reg.mix ^ wi_reg.mix);
        new_m_idx  = (s_eq_i ? 8'h00 : wi_reg.mix) ^ wi_reg.subst;
        w_idx_word = '{subst: new_s_idx, mix: new_m_idx};
    end

    always_comb
    begin
        phase_next = phase_reg;
        start      = 1'b0;
        finish     = 1'b0;
        sm_we      = 1'b0;
        sm_waddr   = idx_reg;
        sm_wdata   = w_idx_word;
        sm_raddr_a = idx_reg;
        sm_raddr_b = chain_reg;
        inv_we     = 1'b0;
        inv_waddr  = new_s_idx;
        inv_wdata  = idx_reg;
        inv_raddr  = hold_data_reg;
        unique case (phase_reg)
            PH_INIT:
            begin
                sm_we     = 1'b1;
                sm_waddr  = init_cnt_reg;
                sm_wdata  = '{subst: SUBST_INIT[init_cnt_reg], mix: MIX_INIT[init_cnt_reg]};
                inv_we    = 1'b1;
                inv_waddr = SUBST_INIT[init_cnt_reg];
                inv_wdata = init_cnt_reg;
                if (init_cnt_reg == 8'hff)
                begin
                    phase_next = PH_IDLE;
                end
            end
            PH_IDLE:
            begin
                if (hold_valid_reg)
                begin
                    start = 1'b1;
                    if (hold_func_reg == FUNC_DECRYPT)
                    begin
                        phase_next = PH_RD;
                    end
                    else
                    begin
                        sm_raddr_a = enc_idx;
                        phase_next = PH_PART;
                    end
                end
            end
            PH_RD:
            begin
                // the inverse entry is the index directly
                sm_raddr_a = inv_rdata;
                phase_next = PH_PART;
            end
            PH_PART:
            begin
                sm_raddr_a = sm_rdata_a.mix;
                phase_next = PH_W1;
            end
            PH_W1:
            begin
                sm_we      = 1'b1;
                inv_we     = 1'b1;
                phase_next = PH_W2;
            end
            PH_W2:
            begin
                sm_we      = wp_en_reg;
                sm_waddr   = partner_reg;
                sm_wdata   = wp_word_reg;
                inv_we     = 1'b1;
                inv_waddr  = wi_reg.subst;
                inv_wdata  = partner_reg;
                phase_next = PH_W3;
            end
            PH_W3:
            begin
                sm_we    = ws_en_reg;
                sm_waddr = chain_reg;
                sm_wdata = ws_word_reg;
                if (!out_valid_reg || out_ready)
                begin
                    finish     = 1'b1;
                    phase_next = PH_IDLE;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_INIT;
            init_cnt_reg   <= '0;
            chain_reg      <= '0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            if (phase_reg == PH_INIT)
            begin
                init_cnt_reg <= init_cnt_reg + 8'd1;
            end
            if (in_take)
            begin
                hold_valid_reg <= 1'b1;
            end
            else if (start)
            begin
                hold_valid_reg <= 1'b0;
            end
            if (finish)
            begin
                out_valid_reg <= 1'b1;
                chain_reg     <= new_chain_reg;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            hold_func_reg <= func;
            hold_data_reg <= data_in;
        end
        if (start)
        begin
            func_reg <= hold_func_reg;
            idx_reg  <= enc_idx;
        end
        if (phase_reg == PH_RD)
        begin
            idx_reg <= inv_rdata;
        end
        if (phase_reg == PH_PART)
        begin
            wi_reg <= sm_rdata_a;
            ws_reg <= sm_rdata_b;
        end
        if (phase_reg == PH_W1)
        begin
            partner_reg   <= partner;
            new_chain_reg <= new_m_idx;
            wp_en_reg     <= !p_eq_i;
            ws_en_reg     <= !s_eq_i && !s_eq_p;
            wp_word_reg   <= '{subst: wi_reg.subst, mix: (s_eq_p ? m_s_new : sm_rdata_a.mix)};
            ws_word_reg   <= '{subst: ws_reg.subst, mix: m_s_new};
            result_reg    <= (func_reg == FUNC_DECRYPT) ? (idx_reg - chain_reg) : wi_reg.subst;
        end
        if (finish)
        begin
            out_data_reg <= result_reg;
        end
    end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stream test of the table shuffle byte cipher: a queue of encrypt/decrypt
// requests feeds a driver, a scoreboard tracks the cipher tables and chain
// state and checks every returned byte in order, with random stalls on both
// sides and one long output back-pressure stretch.
// ----------------------------------------------------------------------------
module tb
    import tsbc_pkg::*;
;

    localparam int STALL_LIMIT   = 4000;
    localparam int RANDOM_TARGET = 1750;
    localparam int HOLD_CYCLES   = 300;

    typedef struct packed {
        logic  f;
        byte_t d;
    } cipher_req_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic       func = FUNC_ENCRYPT;
    logic [7:0] data_in = 8'h00;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] data_out;

    // scoreboard copy of the cipher state
    byte_t chain_byte;
    byte_t perm_tab [TABLE_DEPTH];
    byte_t inv_tab  [TABLE_DEPTH];
    byte_t mix_tab  [TABLE_DEPTH];

    cipher_req_t pending_q [$];
    byte_t       expected_bytes_q [$];

    int   reqs_accepted = 0;
    int   bytes_returned = 0;
    int   fail_count = 0;
    int   stall_cycles = 0;
    int   hold_left = 0;
    logic hold_done = 1'b0;
    logic req_fired = 1'b0;
    logic quiet_span;

    assign quiet_span = (reqs_accepted >= 700) && (reqs_accepted < 1000);

    table_shuffle_byte_stream_cipher_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .func      (func),
        .data_in   (data_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .data_out  (data_out)
    );

    always #4 clk = ~clk;

    function automatic void load_tables();
        chain_byte = 8'h00;
        for (int k = 0; k < TABLE_DEPTH; k++)
        begin
            perm_tab[k] = SUBST_INIT[k];
            mix_tab[k]  = MIX_INIT[k];
            inv_tab[k]  = 8'h00;
        end
        for (int k = 0; k < TABLE_DEPTH; k++)
            inv_tab[perm_tab[k]] = byte_t'(k);
    endfunction

    // encrypt one byte and shuffle/mix the tables
    function automatic byte_t scramble_byte(byte_t plain);
        byte_t idx;
        byte_t outv;
        byte_t partner;
        idx     = chain_byte + plain;
        outv    = perm_tab[idx];
        partner = mix_tab[idx];
        perm_tab[idx]     = perm_tab[partner];
        perm_tab[partner] = outv;
        inv_tab[perm_tab[idx]]     = idx;
        inv_tab[perm_tab[partner]] = partner;
        // when chain equals idx this clears the entry before the next xor
        mix_tab[chain_byte] = mix_tab[chain_byte] ^ mix_tab[idx];
        mix_tab[idx]        = mix_tab[idx] ^ outv;
        chain_byte          = mix_tab[idx];
        return outv;
    endfunction

    function automatic byte_t cipher_predict(logic f, byte_t d);
        byte_t plain;
        if (f == FUNC_ENCRYPT)
            return scramble_byte(d);
        plain = inv_tab[d] - chain_byte;
        void'(scramble_byte(plain));
        return plain;
    endfunction

    // queue a request, advancing the table copy so later requests can be aimed
    function automatic void plan_req(logic f, byte_t d);
        cipher_req_t r;
        r.f = f;
        r.d = d;
        pending_q.push_back(r);
        void'(cipher_predict(f, d));
    endfunction

    // plaintext whose index lands on a self-mapped mixing entry, if any
    function automatic int self_partner_plain();
        byte_t idx;
        for (int k = 0; k < TABLE_DEPTH; k++)
        begin
            idx = chain_byte + byte_t'(k);
            if (mix_tab[idx] == idx)
                return k;
        end
        return -1;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch @%0t: %s", $time, what);
        fail_count++;
    endtask

    // request driver
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || req_fired)
        begin
            if (pending_q.size() != 0 && (quiet_span || $urandom_range(99) >= 6))
            begin
                in_valid <= 1'b1;
                func     <= pending_q[0].f;
                data_in  <= pending_q[0].d;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
        req_fired = 1'b0;
    end

    // request acceptance and prediction
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
        begin
            expected_bytes_q.push_back(cipher_predict(func, data_in));
            void'(pending_q.pop_front());
            reqs_accepted++;
            req_fired = 1'b1;
        end
    end

    // result side ready, with one long hold-off to back the block up
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            out_ready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else if (!hold_done && bytes_returned >= 400)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= quiet_span || ($urandom_range(99) >= 6);
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        byte_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_bytes_q.size() == 0)
            begin
                report_mismatch($sformatf("unexpected byte %02h", data_out));
            end
            else
            begin
                want = expected_bytes_q.pop_front();
                if (data_out !== want)
                    report_mismatch($sformatf("byte %0d: data_out %02h, want %02h",
                                              bytes_returned, data_out, want));
            end
            bytes_returned++;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin : watchdog
        while (stall_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin : stimulus
        int    p;
        int    n;
        logic  f;
        string pass_phrase;

        load_tables();

        // directed: extremes, chain-equals-index, self-swap, key bytes
        plan_req(FUNC_ENCRYPT, 8'h00);
        plan_req(FUNC_ENCRYPT, 8'hff);
        plan_req(FUNC_DECRYPT, 8'h00);
        plan_req(FUNC_DECRYPT, 8'hff);
        plan_req(FUNC_DECRYPT, perm_tab[chain_byte]);
        plan_req(FUNC_ENCRYPT, 8'h55);
        plan_req(FUNC_ENCRYPT, 8'haa);
        plan_req(FUNC_DECRYPT, 8'h55);
        plan_req(FUNC_DECRYPT, 8'haa);
        for (int k = 0; k < 4; k++)
        begin
            p = self_partner_plain();
            if (p >= 0)
                plan_req(FUNC_ENCRYPT, byte_t'(p));
            p = self_partner_plain();
            if (p >= 0)
                plan_req(FUNC_DECRYPT, perm_tab[chain_byte + byte_t'(p)]);
        end
        pass_phrase = "k3y!";
        for (int k = 0; k < pass_phrase.len(); k++)
            plan_req(FUNC_ENCRYPT, byte_t'(pass_phrase[k]));

        // random: mostly keyed sessions, some mixed noise
        n = pending_q.size() + RANDOM_TARGET;
        while (pending_q.size() < n)
        begin
            if ($urandom_range(99) < 80)
            begin
                repeat ($urandom_range(12, 3))
                    plan_req(FUNC_ENCRYPT, byte_t'($urandom_range(255)));
                f = ($urandom_range(1) == 0) ? FUNC_ENCRYPT : FUNC_DECRYPT;
                repeat ($urandom_range(48, 8))
                    plan_req(f, byte_t'($urandom_range(255)));
            end
            else
            begin
                repeat ($urandom_range(10, 1))
                    plan_req(($urandom_range(1) == 0) ? FUNC_ENCRYPT : FUNC_DECRYPT,
                             byte_t'($urandom_range(255)));
            end
        end

        // planning moved the tables; start the scoreboard from reset contents
        load_tables();

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_q.size() != 0 || expected_bytes_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
